@@ hdl/mvsm_pkg.sv @@
// Shared types and constants for the multi-voice sample mixer.
// No dependencies.
`default_nettype none

package mvsm_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_PLAY = 2'd1,
    OP_LOAD = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PSCAN,
    ST_PWRITE,
    ST_TICK,
    ST_TOUT
  } st_t;

  typedef struct packed {
    logic [16:0] pos;
    logic [16:0] vend;
    logic [15:0] frac;
    logic [17:0] step;
    logic [6:0]  lgain;
    logic [6:0]  rgain;
    logic [7:0]  tag;
    logic [31:0] stamp;
  } voice_t;

  localparam int          MIX_W       = 17;
  localparam logic [22:0] GAIN_RECIP  = 23'd4227331; // ceil(2^29 / 127)
  localparam int          GAIN_SHIFT  = 21;
  localparam logic [6:0]  PAN_DEFAULT = 7'd50;
  localparam logic [7:0]  VOL_DEFAULT = 8'd8;
  localparam logic [16:0] LEN_MAX     = 17'd65536;

endpackage

`default_nettype wire

@@ hdl/mvsm_ram.sv @@
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module mvsm_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                   wdata,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output      logic [W-1:0]                   rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/mvsm_gain.sv @@
// Two-stage gain unit: g*(b-128)*256/127, truncated toward zero.
// Depends on mvsm_pkg.
`default_nettype none

module mvsm_gain import mvsm_pkg::*; (
  input  wire logic                    clk,
  input  wire logic [6:0]              g,
  input  wire logic [7:0]              b,
  output      logic signed [MIX_W-1:0] q
);

  logic        neg;
  logic [7:0]  mag;
  logic [14:0] y;
  logic        n1;
  logic [37:0] p;
  logic        n2;
  logic [MIX_W-1:0] m;

  always_comb begin
    neg = (b < 8'd128);
    mag = neg ? 8'(9'd128 - {1'b0, b}) : 8'(b - 8'd128);
  end

  always_ff @(posedge clk) begin
    y  <= g * mag;
    n1 <= neg;
    p  <= y * GAIN_RECIP;
    n2 <= n1;
  end

  always_comb begin
    m = MIX_W'(p >> GAIN_SHIFT);
    q = n2 ? -signed'(m) : signed'(m);
  end

endmodule

`default_nettype wire

@@ hdl/multi_voice_sample_mixer.sv @@
// Top level of the multi-voice sample mixer: control, voice RAM, sample RAM.
// Depends on mvsm_pkg, mvsm_ram, mvsm_gain.
//
// channel  dir  fields (tdata/tuser from bit 0 up)
// s_*      in   tuser: op; tdata: addr, byte, length, step, volume, sep, id, only_one
// m_*      out  tdata: left, right, active_voices
//
// Load: sample RAM write. Play: voice RAM scan, one read a cycle, then write.
// Tick: one voice RAM read per cycle through the sample read and
// gain pipeline; holds while the previous frame is not yet taken.
// Sample depth must be a power of two. rst is synchronous; voice RAM needs no clearing.
`default_nettype none

module multi_voice_sample_mixer import mvsm_pkg::*; #(
  parameter int VOICES           = 8,
  parameter int SAMPLE_MEM_DEPTH = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [87:0] s_tdata,  // addr, byte, length, step, volume, sep, id, only_one
  input  wire logic [1:0]  s_tuser,  // op
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [39:0] m_tdata   // left, right, active_voices
);

  localparam int VW  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW  = $clog2(VOICES + 5);
  localparam int SMW = $clog2(SAMPLE_MEM_DEPTH);
  localparam int ACW = MIX_W + $clog2(VOICES) + 1;
  localparam logic signed [ACW-1:0] SMAX = ACW'(32767);
  localparam logic signed [ACW-1:0] SMIN = ACW'(-32768);
  localparam int VBW = $bits(voice_t);

  st_t st, st_next;
  logic [CW-1:0] cnt;
  logic accept;

  logic [15:0] in_addr;
  logic [7:0]  in_byte;
  logic [16:0] in_len;
  logic [17:0] in_step;
  logic [8:0]  in_vol, in_sep;
  logic [7:0]  in_id;
  logic        in_only;

  assign in_addr = s_tdata[15:0];
  assign in_byte = s_tdata[23:16];
  assign in_len  = s_tdata[40:24];
  assign in_step = s_tdata[58:41];
  assign in_vol  = s_tdata[67:59];
  assign in_sep  = s_tdata[76:68];
  assign in_id   = s_tdata[84:77];
  assign in_only = s_tdata[85];
  assign accept  = s_tvalid && s_tready;

  logic [15:0] it_addr;
  logic [16:0] it_len;
  logic [17:0] it_step;
  logic [7:0]  it_vol;
  logic [8:0]  it_s;
  logic [7:0]  it_tag;
  logic        it_only;
  logic [16:0] sq_l, sq_r;
  logic [24:0] prod_l, prod_r;
  logic [6:0]  gl, gr;

  logic [31:0] play_cnt;
  logic [VOICES-1:0] act, act_rem, act_new;
  logic        stop_hit;
  logic [VW-1:0] stop_idx, old_idx, slot;
  logic [31:0] old_stamp;

  logic          issue, r_vld;
  logic [VW-1:0] r_idx;
  logic [VBW-1:0] vr_rdata;
  voice_t        vr, vw_data;
  logic          vw_we;
  logic [VW-1:0] vw_addr;
  logic [18:0]   acc19;
  logic [17:0]   npos;
  logic          vdone, tick_upd;

  logic          t2_vld, t3_vld, t4_vld;
  logic [6:0]    t2_lg, t2_rg;
  logic [7:0]    sm_rdata;
  logic signed [MIX_W-1:0] ql, qr;
  logic signed [ACW-1:0]   acc_l, acc_r;
  logic [15:0]   sat_l, sat_r;
  logic          out_load;

  // next state
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(s_tuser))
            OP_PLAY: st_next = ST_PSCAN;
            OP_TICK: st_next = ST_TICK;
            default: st_next = ST_IDLE;
          endcase
        end
      end
      ST_PSCAN:  if (cnt == CW'(VOICES)) st_next = ST_PWRITE;
      ST_PWRITE: st_next = ST_IDLE;
      ST_TICK:   if (cnt == CW'(VOICES + 4)) st_next = ST_TOUT;
      ST_TOUT:   if (!m_tvalid || m_tready) st_next = ST_IDLE;
      default:   st_next = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    s_tready = (st == ST_IDLE);
    issue    = (st == ST_PSCAN || st == ST_TICK) && (cnt < CW'(VOICES));
    out_load = (st == ST_TOUT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= ST_IDLE;
      cnt <= '0;
    end else begin
      st <= st_next;
      if (st_next != st) begin
        cnt <= '0;
      end else if (st == ST_PSCAN || st == ST_TICK) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // item capture and pan law
  always_ff @(posedge clk) begin
    if (accept) begin
      it_addr <= in_addr;
      it_len  <= (in_len > LEN_MAX) ? LEN_MAX : in_len;
      it_step <= in_step;
      it_vol  <= (in_vol > 9'd255) ? VOL_DEFAULT : in_vol[7:0];
      it_s    <= (in_sep >= 9'd1 && in_sep <= 9'd256) ? (in_sep + 9'd1) : 9'd1;
      it_tag  <= in_id;
      it_only <= in_only;
    end
    sq_l   <= it_s * it_s;
    sq_r   <= (9'd257 - it_s) * (9'd257 - it_s);
    prod_l <= it_vol * sq_l;
    prod_r <= it_vol * sq_r;
  end

  always_comb begin
    logic signed [9:0] dl, dr;
    dl = signed'({2'b00, it_vol}) - signed'({1'b0, prod_l[24:16]});
    dr = signed'({2'b00, it_vol}) - signed'({1'b0, prod_r[24:16]});
    gl = (dl < 0 || dl > 10'sd127) ? PAN_DEFAULT : dl[6:0];
    gr = (dr < 0 || dr > 10'sd127) ? PAN_DEFAULT : dr[6:0];
  end

  // voice RAM read pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else begin
      r_vld <= issue;
    end
    r_idx <= cnt[VW-1:0];
  end

  assign vr = voice_t'(vr_rdata);

  // play scan: exclusive stop and oldest stamp
  always_ff @(posedge clk) begin
    if (accept) begin
      stop_hit  <= 1'b0;
      old_stamp <= play_cnt;
      old_idx   <= '0;
    end else if (st == ST_PSCAN && r_vld) begin
      if (it_only && act[r_idx] && vr.tag == it_tag && !stop_hit) begin
        stop_hit <= 1'b1;
        stop_idx <= r_idx;
      end
      if (vr.stamp < old_stamp) begin
        old_stamp <= vr.stamp;
        old_idx   <= r_idx;
      end
    end
  end

  always_comb begin
    act_rem = act;
    if (stop_hit) begin
      act_rem[stop_idx] = 1'b0;
    end
    slot = old_idx;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!act_rem[i]) begin
        slot = VW'(i);
      end
    end
    act_new       = act_rem;
    act_new[slot] = 1'b1;
  end

  // tick update of one voice
  always_comb begin
    acc19    = {3'b000, vr.frac} + {1'b0, vr.step};
    npos     = {1'b0, vr.pos} + {15'd0, acc19[18:16]};
    vdone    = npos >= {1'b0, vr.vend};
    tick_upd = (st == ST_TICK) && r_vld && act[r_idx];
  end

  always_comb begin
    vw_we   = 1'b0;
    vw_addr = r_idx;
    vw_data = vr;
    if (st == ST_PWRITE) begin
      vw_we         = 1'b1;
      vw_addr       = slot;
      vw_data.pos   = {1'b0, it_addr};
      vw_data.vend  = {1'b0, it_addr} + it_len;
      vw_data.frac  = '0;
      vw_data.step  = it_step;
      vw_data.lgain = gl;
      vw_data.rgain = gr;
      vw_data.tag   = it_tag;
      vw_data.stamp = play_cnt;
    end else if (tick_upd) begin
      vw_we        = 1'b1;
      vw_data.pos  = npos[16:0];
      vw_data.frac = acc19[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act      <= '0;
      play_cnt <= 32'd1;
    end else if (st == ST_PWRITE) begin
      act      <= act_new;
      play_cnt <= play_cnt + 32'd1;
    end else if (tick_upd && vdone) begin
      act[r_idx] <= 1'b0;
    end
  end

  mvsm_ram #(.W(VBW), .D(VOICES)) u_voice_ram (
    .clk   (clk),
    .we    (vw_we),
    .waddr (vw_addr),
    .wdata (VBW'(vw_data)),
    .raddr (cnt[VW-1:0]),
    .rdata (vr_rdata)
  );

  mvsm_ram #(.W(8), .D(SAMPLE_MEM_DEPTH)) u_sample_ram (
    .clk   (clk),
    .we    (accept && op_t'(s_tuser) == OP_LOAD),
    .waddr (SMW'(in_addr)),
    .wdata (in_byte),
    .raddr (SMW'(vr.pos)),
    .rdata (sm_rdata)
  );

  // mix pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      t2_vld <= 1'b0;
      t3_vld <= 1'b0;
      t4_vld <= 1'b0;
    end else begin
      t2_vld <= tick_upd;
      t3_vld <= t2_vld;
      t4_vld <= t3_vld;
    end
    t2_lg <= vr.lgain;
    t2_rg <= vr.rgain;
  end

  mvsm_gain u_gain_l (.clk(clk), .g(t2_lg), .b(sm_rdata), .q(ql));
  mvsm_gain u_gain_r (.clk(clk), .g(t2_rg), .b(sm_rdata), .q(qr));

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (t4_vld) begin
      acc_l <= acc_l + ACW'(ql);
      acc_r <= acc_r + ACW'(qr);
    end
  end

  always_comb begin
    sat_l = (acc_l > SMAX) ? 16'h7fff : (acc_l < SMIN) ? 16'h8000 : acc_l[15:0];
    sat_r = (acc_r > SMAX) ? 16'h7fff : (acc_r < SMIN) ? 16'h8000 : acc_r[15:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (out_load) begin
      m_tdata <= {8'(act), sat_r, sat_l};
    end
  end

  a_act_hold: assert property (@(posedge clk) disable iff (rst)
    (st != ST_PWRITE && !tick_upd) |=> act == $past(act))
    else $error("voice active bits changed outside play write or tick update");

  a_slot_set: assert property (@(posedge clk) disable iff (rst)
    (st == ST_PWRITE) |=> act[$past(slot)])
    else $error("started voice not active");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (st == ST_PWRITE) |=> play_cnt == $past(play_cnt) + 32'd1)
    else $error("play counter did not advance on voice start");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(st) == ST_TOUT)
    else $error("frame issued outside output state");

endmodule

`default_nettype wire

@@ bench/multi_voice_sample_mixer_check.sv @@
// Checker for the multi-voice sample mixer: watches both stream channels,
// predicts every stereo frame and compares it with the block's output.
// Depends on mvsm_pkg.
`default_nettype none

module multi_voice_sample_mixer_check import mvsm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [87:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [39:0] m_tdata,
  output int               fails,
  output int               frames_pending,
  output int               frames_checked
);

  typedef struct packed {
    logic [7:0]  active;
    logic [15:0] right;
    logic [15:0] left;
  } frame_t;

  frame_t      frame_q[$];
  logic [7:0]  mem [65536];
  bit          v_on    [8];
  int unsigned v_pos   [8];
  int unsigned v_end   [8];
  int unsigned v_frac  [8];
  int unsigned v_step  [8];
  int unsigned v_lg    [8];
  int unsigned v_rg    [8];
  int unsigned v_tag   [8];
  int unsigned v_stamp [8];
  int unsigned play_count;

  function automatic int scaled(int g, int b);
    return (g * (b - 128) * 256) / 127;
  endfunction

  function automatic int unsigned pan(int vol, int s);
    int g;
    g = vol - (vol * s * s) / 65536;
    if (g < 0 || g > 127) g = 50;
    return g;
  endfunction

  task automatic start_voice(logic [87:0] d);
    int unsigned addr, len, stamp_min;
    int vol, sep, v, slot, oldest;
    addr = d[15:0];
    len  = d[40:24];
    vol  = d[67:59];
    sep  = d[76:68];
    if (len > 65536) len = 65536;
    if (sep < 1 || sep > 256) sep = 0;
    if (vol > 255) vol = 8;
    if (d[85]) begin
      for (v = 0; v < 8; v++) begin
        if (v_on[v] && v_tag[v] == d[84:77]) begin
          v_on[v] = 0;
          break;
        end
      end
    end
    stamp_min = play_count;
    oldest = 0;
    for (v = 0; v < 8 && v_on[v]; v++) begin
      if (v_stamp[v] < stamp_min) begin
        oldest = v;
        stamp_min = v_stamp[v];
      end
    end
    slot = (v == 8) ? oldest : v;
    v_on[slot]    = 1;
    v_pos[slot]   = addr;
    v_end[slot]   = addr + len;
    v_step[slot]  = d[58:41];
    v_frac[slot]  = 0;
    v_stamp[slot] = play_count;
    v_tag[slot]   = d[84:77];
    v_lg[slot]    = pan(vol, sep + 1);
    v_rg[slot]    = pan(vol, sep + 1 - 257);
    play_count++;
  endtask

  task automatic mix_frame();
    int dl, dr, b, v;
    int unsigned acc, pos;
    frame_t f;
    dl = 0;
    dr = 0;
    f.active = '0;
    for (v = 0; v < 8; v++) begin
      if (v_on[v]) begin
        b = mem[v_pos[v][15:0]];
        dl += scaled(v_lg[v], b);
        dr += scaled(v_rg[v], b);
        acc = v_frac[v] + v_step[v];
        pos = v_pos[v] + (acc >> 16);
        v_frac[v] = acc & 32'hFFFF;
        if (pos >= v_end[v]) begin
          v_on[v] = 0;
          v_pos[v] = pos & 32'h1FFFF;
        end else begin
          v_pos[v] = pos;
          f.active[v] = 1'b1;
        end
      end
    end
    if (dl > 32767) dl = 32767;
    if (dl < -32768) dl = -32768;
    if (dr > 32767) dr = 32767;
    if (dr < -32768) dr = -32768;
    f.left = dl[15:0];
    f.right = dr[15:0];
    frame_q.push_back(f);
  endtask

  initial begin
    fails = 0;
    frames_checked = 0;
    frames_pending = 0;
    play_count = 1;
    for (int v = 0; v < 8; v++) begin
      v_on[v] = 0; v_pos[v] = 0; v_end[v] = 0; v_frac[v] = 0; v_step[v] = 0;
      v_lg[v] = 0; v_rg[v] = 0; v_tag[v] = 0; v_stamp[v] = 0;
    end
  end

  always @(posedge clk) begin
    frame_t exp_f, got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (frame_q.size() == 0) begin
          $error("frame with none expected: %h", m_tdata);
          fails++;
        end else begin
          exp_f = frame_q.pop_front();
          frames_checked++;
          if (got.active != exp_f.active) begin
            $error("active_voices: expected %h, got %h", exp_f.active, got.active);
            fails++;
          end
          if (got.right != exp_f.right) begin
            $error("right_sample: expected %0d, got %0d",
                   $signed(exp_f.right), $signed(got.right));
            fails++;
          end
          if (got.left != exp_f.left) begin
            $error("left_sample: expected %0d, got %0d",
                   $signed(exp_f.left), $signed(got.left));
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          OP_LOAD: mem[s_tdata[15:0]] = s_tdata[23:16];
          OP_PLAY: start_voice(s_tdata);
          OP_TICK: mix_frame();
          default: ;
        endcase
      end
    end
    frames_pending = frame_q.size();
  end

endmodule

`default_nettype wire

@@ bench/multi_voice_sample_mixer_test.sv @@
// Top of the mixer bench: clock, reset, stimulus with bursty sender and
// stalling receiver, and the verdict. Depends on mvsm_pkg, the mixer and
// multi_voice_sample_mixer_check.
`default_nettype none

module multi_voice_sample_mixer_test;
  import mvsm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int LIMIT = 200000;
  localparam int WIN   = 256;

  logic        clk, rst;
  logic        s_tvalid, s_tready, m_tvalid, m_tready;
  logic [87:0] s_tdata;
  logic [1:0]  s_tuser;
  logic [39:0] m_tdata;
  int          fails, frames_pending, frames_checked;
  int          burst_left, stall_mode, cycles, n_loads, n_plays;

  multi_voice_sample_mixer uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  multi_voice_sample_mixer_check chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fails(fails), .frames_pending(frames_pending), .frames_checked(frames_checked)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: stall pattern changes character every so often
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 1) != 0);
      default: m_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  task automatic send(logic [1:0] op, logic [87:0] d);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load(int unsigned addr, int unsigned b);
    n_loads++;
    send(OP_LOAD, {64'd0, b[7:0], addr[15:0]});
  endtask

  task automatic play(int unsigned addr, int unsigned len, int unsigned step,
                      int unsigned vol, int unsigned sep, int unsigned id, bit only);
    n_plays++;
    send(OP_PLAY, {2'b0, only, id[7:0], sep[8:0], vol[8:0], step[17:0], len[16:0],
                   8'd0, addr[15:0]});
  endtask

  task automatic tick();
    send(OP_TICK, 88'({$urandom, $urandom, $urandom}));
  endtask

  task automatic idle_wait();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (frames_pending != 0) @(negedge clk);
  endtask

  // sounds stay inside the written window; long ones do not move
  task automatic random_play();
    int unsigned addr, len, step, vol, sep, id;
    addr = $urandom_range(0, WIN - 1);
    if ($urandom_range(0, 9) == 0) begin
      len  = $urandom_range(0, 131071);
      step = 0;
    end else begin
      len  = $urandom_range(0, WIN - addr);
      step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 262143)
                                         : $urandom_range(0, 32'h30000);
    end
    vol  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 255);
    sep  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 256);
    id   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
    play(addr, len, step, vol, sep, id, $urandom_range(0, 1));
  endtask

  initial begin
    int r;
    rst = 1; s_tvalid = 0; s_tuser = OP_TICK; s_tdata = '0; m_tready = 0;
    cycles = 0; burst_left = 0; stall_mode = 0; n_loads = 0; n_plays = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(negedge clk);

    // sample window and the top byte written first so no voice reads an unwritten byte
    for (int a = 0; a < WIN; a++) begin
      if (a == 0) load(a, 0);
      else if (a == WIN - 1) load(a, 255);
      else load(a, $urandom_range(0, 255));
    end
    load(65535, 255);

    play(0, 0, 65536, 255, 1, 1, 0);          // zero length, left gain out of range
    tick();
    play(65535, 20, 262143, 0, 256, 2, 0);    // top address wrapping to 0, max step
    play(100, 131071, 0, 300, 0, 3, 0);       // length clamp, out-of-range volume, sep 0
    tick();
    play(200, 10, 65536, 128, 257, 3, 1);     // exclusive: stops the tag 3 voice
    play(150, 50, 1, 200, 511, 4, 1);
    tick();
    tick();
    for (int i = 0; i < 7; i++) play(10 + i, 200, 40000, 255 - i, 128, 7, 0);
    tick();
    send(OP_UNUSED, '1);
    load(65535, 128);
    tick();
    tick();

    for (int i = 0; i < 420; i++) begin
      if (i == 210) idle_wait();
      r = $urandom_range(0, 99);
      if (r < 50) tick();
      else if (r < 75) random_play();
      else if (r < 95) load($urandom_range(0, 65535), $urandom_range(0, 255));
      else send(OP_UNUSED, 88'({$urandom, $urandom, $urandom}));
    end

    idle_wait();
    repeat (40) @(posedge clk);
    $display("covered %0d sample writes, %0d voice starts, %0d frames compared",
             n_loads, n_plays, frames_checked);
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
